// ----- sv/dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, codes and controller/datapath types of the frame deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

   localparam int FRAME_LENGTH = 6;

   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h5A;
   localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'hFF;

   localparam logic [BYTE_W-1:0] CODE_PAGE_ONE = 8'h01;
   localparam logic [BYTE_W-1:0] CODE_PAGE_TWO = 8'h02;

   localparam logic [STATUS_W-1:0] STATUS_PAGE_ONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PAGE_TWO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = 2'd1;

   typedef struct packed {
      logic take;
      logic close;
      logic replay;
   } dfr_cmd_type;

   typedef struct packed {
      logic closing;
      logic frame_good;
   } dfr_sts_type;

endpackage

// ----- sv/dfr_req_if.sv -----
// ----------------------------------------------------------------------------
// dfr_req_if
// Received byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
interface dfr_req_if;

   logic                        valid;
   logic                        ready;
   logic [dfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

// ----- sv/dfr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dfr_rsp_if
// Frame result channel: valid/ready handshake, one frame report per word.
// ----------------------------------------------------------------------------
interface dfr_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [dfr_pkg::STATUS_W-1:0] frame_status;
   logic [dfr_pkg::BYTE_W-1:0]   function_code;
   logic [dfr_pkg::BYTE_W-1:0]   data_first;
   logic [dfr_pkg::BYTE_W-1:0]   data_second;

   modport source (output valid, output frame_status, output function_code,
                   output data_first, output data_second, input ready);
   modport sink   (input valid, input frame_status, input function_code,
                   input data_first, input data_second, output ready);

endinterface

// ----- sv/serial_xor_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// serial_xor_frame_deframer
// Report: a closing byte gives its frame report on rsp in the cycle after accept.
// Throughput: one byte per cycle but for stalls on a pending report and while
// the replay line feeds a bad frame's held bytes back through the start hunt.
// Reset: synchronous; start/end bytes to 0x5A/0xFF, parser back to hunting.
// ----------------------------------------------------------------------------
module serial_xor_frame_deframer #(
   parameter int FrameLength = dfr_pkg::FRAME_LENGTH
) (
   input  logic                          clock,
   input  logic                          reset,
   dfr_req_if.sink                       req,
   dfr_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [dfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dfr_pkg::BYTE_W-1:0]    csr_wdata
);

   dfr_pkg::dfr_cmd_type cmd;
   dfr_pkg::dfr_sts_type sts;

   dfr_ctrl #(
      .FrameLength (FrameLength)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dfr_datapath #(
      .FrameLength (FrameLength)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rx_byte       (req.rx_byte),
      .cmd           (cmd),
      .sts           (sts),
      .frame_status  (rsp.frame_status),
      .function_code (rsp.function_code),
      .data_first    (rsp.data_first),
      .data_second   (rsp.data_second)
   );

`ifndef SYNTHESIS
   a_bad_starts_replay: assert property (@(posedge clock) disable iff (reset)
      (cmd.close && !sts.frame_good) |=> (cmd.replay && !req.ready))
      else $error("bad frame did not start replay");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.close |-> (!rsp.valid || rsp.ready))
      else $error("frame report overwrote a pending word");

   a_close_gives_word: assert property (@(posedge clock) disable iff (reset)
      cmd.close |=> rsp.valid)
      else $error("closed frame gave no word");

   a_replay_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.replay |-> !(cmd.take || cmd.close))
      else $error("byte accepted during replay");
`endif

endmodule

// ----- sv/dfr_datapath.sv -----
// ----------------------------------------------------------------------------
// dfr_datapath
// Frame hold registers, running XOR, replay shift line, config registers and
// the result register.
// ----------------------------------------------------------------------------
module dfr_datapath #(
   parameter int FrameLength = dfr_pkg::FRAME_LENGTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dfr_pkg::BYTE_W-1:0]      csr_wdata,
   input  logic [dfr_pkg::BYTE_W-1:0]      rx_byte,
   input  dfr_pkg::dfr_cmd_type            cmd,
   output dfr_pkg::dfr_sts_type            sts,
   output logic [dfr_pkg::STATUS_W-1:0]    frame_status,
   output logic [dfr_pkg::BYTE_W-1:0]      function_code,
   output logic [dfr_pkg::BYTE_W-1:0]      data_first,
   output logic [dfr_pkg::BYTE_W-1:0]      data_second
);

   localparam int HoldDepth = FrameLength - 1;
   localparam int CheckPos  = FrameLength - 2;
   localparam int PosW      = $clog2(FrameLength);
   localparam int SecondIdx = (FrameLength > 4) ? 3 : 0;

   logic [dfr_pkg::BYTE_W-1:0]   start_ff, end_ff;
   logic [PosW-1:0]              pos_ff, pos_in;
   logic [dfr_pkg::BYTE_W-1:0]   xor_ff, xor_in;
   logic [dfr_pkg::BYTE_W-1:0]   held_ff [HoldDepth];
   logic [dfr_pkg::BYTE_W-1:0]   rep_ff  [HoldDepth];
   logic [HoldDepth-1:0]         held_we;
   logic [dfr_pkg::BYTE_W-1:0]   in_byte;
   logic [dfr_pkg::BYTE_W-1:0]   second_byte;
   logic [dfr_pkg::STATUS_W-1:0] status_in;
   logic [dfr_pkg::STATUS_W-1:0] status_ff;
   logic [dfr_pkg::BYTE_W-1:0]   code_ff, first_ff, second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= dfr_pkg::START_BYTE_RESET;
         end_ff   <= dfr_pkg::END_BYTE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dfr_pkg::CSR_START_BYTE: start_ff <= csr_wdata;
            dfr_pkg::CSR_END_BYTE:   end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_byte = cmd.replay ? rep_ff[0] : rx_byte;
      pos_in  = pos_ff;
      xor_in  = xor_ff;
      held_we = '0;
      if (cmd.take || cmd.replay) begin
         if (pos_ff == '0) begin
            if (in_byte == start_ff) begin
               held_we[0] = 1'b1;
               xor_in     = in_byte;
               pos_in     = PosW'(1);
            end
         end else if (pos_ff < PosW'(HoldDepth)) begin
            if (pos_ff < PosW'(CheckPos)) begin
               xor_in = xor_ff ^ in_byte;
            end
            for (int i = 0; i < HoldDepth; i++) begin
               held_we[i] = (pos_ff == PosW'(i));
            end
            pos_in = pos_ff + 1'b1;
         end
      end
      if (cmd.close) begin
         pos_in = '0;
         xor_in = '0;
      end
   end

   always_comb begin
      sts.closing    = (pos_ff == PosW'(HoldDepth));
      sts.frame_good = (rx_byte == end_ff) && (xor_ff == held_ff[CheckPos]);
      second_byte    = (FrameLength > 4) ? held_ff[SecondIdx] : rx_byte;
      if (!sts.frame_good) begin
         status_in = dfr_pkg::STATUS_BAD;
      end else if (held_ff[1] == dfr_pkg::CODE_PAGE_ONE) begin
         status_in = dfr_pkg::STATUS_PAGE_ONE;
      end else if (held_ff[1] == dfr_pkg::CODE_PAGE_TWO) begin
         status_in = dfr_pkg::STATUS_PAGE_TWO;
      end else begin
         status_in = dfr_pkg::STATUS_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         xor_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HoldDepth; i++) begin
         if (held_we[i]) begin
            held_ff[i] <= in_byte;
         end
      end
   end

   // replay line holds frame bytes 1 .. FrameLength-1, shifted out at tap 0
   always_ff @(posedge clock) begin
      if (cmd.close && !sts.frame_good) begin
         for (int i = 0; i < HoldDepth - 1; i++) begin
            rep_ff[i] <= held_ff[i+1];
         end
         rep_ff[HoldDepth-1] <= rx_byte;
      end else if (cmd.replay) begin
         for (int i = 0; i < HoldDepth - 1; i++) begin
            rep_ff[i] <= rep_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close) begin
         status_ff <= status_in;
         if (sts.frame_good) begin
            code_ff   <= held_ff[1];
            first_ff  <= held_ff[2];
            second_ff <= second_byte;
         end else begin
            code_ff   <= '0;
            first_ff  <= '0;
            second_ff <= '0;
         end
      end
   end

   assign frame_status  = status_ff;
   assign function_code = code_ff;
   assign data_first    = first_ff;
   assign data_second   = second_ff;

endmodule

// ----- sv/dfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfr_ctrl
// Handshake control, replay sequencer and result valid flag.
// ----------------------------------------------------------------------------
module dfr_ctrl #(
   parameter int FrameLength = dfr_pkg::FRAME_LENGTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dfr_pkg::dfr_sts_type  sts,
   output dfr_pkg::dfr_cmd_type  cmd
);

   localparam int HoldDepth = FrameLength - 1;
   localparam int CntW      = $clog2(HoldDepth);

   localparam logic StIdle   = 1'b0;
   localparam logic StReplay = 1'b1;

   logic            state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;

   always_comb begin
      req_ready  = (state_ff == StIdle) &&
                   (!sts.closing || !rsp_valid_ff || rsp_ready);
      accept     = req_valid && req_ready;
      cmd.take   = accept && !sts.closing;
      cmd.close  = accept && sts.closing;
      cmd.replay = (state_ff == StReplay);

      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         StIdle: begin
            if (cmd.close && !sts.frame_good) begin
               state_in = StReplay;
               cnt_in   = CntW'(HoldDepth - 1);
            end
         end
         StReplay: begin
            if (cnt_ff == '0) begin
               state_in = StIdle;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = StIdle;
      endcase

      if (cmd.close) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/dfr_frame_checker.sv -----
// ----------------------------------------------------------------------------
// dfr_frame_checker
// Watches the byte, report and register ports of the frame deframer, keeps
// its own copy of the parser and the start/end byte registers, predicts a
// frame report for every closing word and compares each report on rsp with
// the oldest one predicted. All ports change only at rising edges, so they
// are sampled at the falling edge ahead of the edge that acts on them.
// ----------------------------------------------------------------------------
module dfr_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [dfr_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [dfr_pkg::STATUS_W-1:0]  rsp_frame_status,
   input  logic [dfr_pkg::BYTE_W-1:0]    rsp_function_code,
   input  logic [dfr_pkg::BYTE_W-1:0]    rsp_data_first,
   input  logic [dfr_pkg::BYTE_W-1:0]    rsp_data_second,
   input  logic                          csr_we,
   input  logic [dfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dfr_pkg::BYTE_W-1:0]    csr_wdata,
   output int unsigned                   fail_count,
   output int unsigned                   reports_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_DEPTH = dfr_pkg::FRAME_LENGTH - 1;
   localparam int CHECK_POS  = dfr_pkg::FRAME_LENGTH - 2;

   typedef struct packed {
      logic [dfr_pkg::STATUS_W-1:0] frame_status;
      logic [dfr_pkg::BYTE_W-1:0]   function_code;
      logic [dfr_pkg::BYTE_W-1:0]   data_first;
      logic [dfr_pkg::BYTE_W-1:0]   data_second;
   } frame_report_type;

   frame_report_type           expected_reports[$];
   logic [dfr_pkg::BYTE_W-1:0] start_value;
   logic [dfr_pkg::BYTE_W-1:0] end_value;
   logic [dfr_pkg::BYTE_W-1:0] running_xor;
   logic [dfr_pkg::BYTE_W-1:0] held_bytes [HOLD_DEPTH];
   int unsigned                frame_fill;

   // one byte that cannot close a frame: start hunt or collect
   function automatic void take_frame_byte(input logic [dfr_pkg::BYTE_W-1:0] rx);
      if (frame_fill == 0) begin
         if (rx == start_value) begin
            held_bytes[0] = rx;
            running_xor   = rx;
            frame_fill    = 1;
         end
      end else if (frame_fill < HOLD_DEPTH) begin
         if (frame_fill < CHECK_POS) running_xor ^= rx;
         held_bytes[frame_fill] = rx;
         frame_fill++;
      end
   endfunction

   function automatic void accept_rx_byte(input logic [dfr_pkg::BYTE_W-1:0] rx);
      logic [dfr_pkg::BYTE_W-1:0] frame [dfr_pkg::FRAME_LENGTH];
      frame_report_type           report;
      logic                       good;
      if (frame_fill < HOLD_DEPTH) begin
         take_frame_byte(rx);
         return;
      end
      for (int i = 0; i < HOLD_DEPTH; i++) frame[i] = held_bytes[i];
      frame[dfr_pkg::FRAME_LENGTH-1] = rx;
      good        = (rx == end_value) && (running_xor == frame[CHECK_POS]);
      frame_fill  = 0;
      running_xor = '0;
      if (good) begin
         case (frame[1])
            dfr_pkg::CODE_PAGE_ONE: report.frame_status = dfr_pkg::STATUS_PAGE_ONE;
            dfr_pkg::CODE_PAGE_TWO: report.frame_status = dfr_pkg::STATUS_PAGE_TWO;
            default:                report.frame_status = dfr_pkg::STATUS_UNKNOWN;
         endcase
         report.function_code = frame[1];
         report.data_first    = frame[2];
         report.data_second   = frame[3];
         expected_reports.push_back(report);
      end else begin
         report = '{frame_status: dfr_pkg::STATUS_BAD, default: '0};
         expected_reports.push_back(report);
         // held bytes after the start go back through the hunt
         for (int i = 1; i < dfr_pkg::FRAME_LENGTH; i++) take_frame_byte(frame[i]);
      end
   endfunction

   always @(negedge clock) begin
      frame_report_type want;
      if (reset) begin
         fail_count  = 0;
         start_value = dfr_pkg::START_BYTE_RESET;
         end_value   = dfr_pkg::END_BYTE_RESET;
         running_xor = '0;
         frame_fill  = 0;
         expected_reports.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
               $error("frame report with none expected: frame_status %0d",
                      rsp_frame_status);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_frame_status !== want.frame_status) begin
                  $error("frame_status: expected %0d, actual %0d",
                         want.frame_status, rsp_frame_status);
                  fail_count++;
               end
               if (rsp_function_code !== want.function_code) begin
                  $error("function_code: expected %0h, actual %0h",
                         want.function_code, rsp_function_code);
                  fail_count++;
               end
               if (rsp_data_first !== want.data_first) begin
                  $error("data_first: expected %0h, actual %0h",
                         want.data_first, rsp_data_first);
                  fail_count++;
               end
               if (rsp_data_second !== want.data_second) begin
                  $error("data_second: expected %0h, actual %0h",
                         want.data_second, rsp_data_second);
                  fail_count++;
               end
            end
         end
         if (csr_we === 1'b1) begin
            if (csr_index == dfr_pkg::CSR_START_BYTE) start_value = csr_wdata;
            else if (csr_index == dfr_pkg::CSR_END_BYTE) end_value = csr_wdata;
         end
         if (req_valid === 1'b1 && req_ready === 1'b1) accept_rx_byte(req_rx_byte);
      end
      reports_pending = expected_reports.size();
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Top of the frame deframer bench: drives received bytes and the start/end
// byte registers, stalls the report side at random, and gives the verdict
// from the checker's failure count. A short directed run covers the frame
// kinds and the replay; random phases then run well-formed frames with
// random content, broken frames and noise under several register settings.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int PHASE_WORDS     = 180;
   localparam int CHECK_POS       = dfr_pkg::FRAME_LENGTH - 2;

   localparam logic [dfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [dfr_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum int {
      FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_END, FRAME_NOISE
   } frame_kind_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [dfr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dfr_pkg::BYTE_W-1:0]    csr_wdata;
   int unsigned                   fail_count;
   int unsigned                   reports_pending;
   int unsigned                   words_sent;
   int unsigned                   cycle_count;
   bit                            gap_free;
   int unsigned                   hold_off_requests;

   dfr_req_if req_bus ();
   dfr_rsp_if rsp_bus ();

   serial_xor_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dfr_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_rx_byte       (req_bus.rx_byte),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_frame_status  (rsp_bus.frame_status),
      .rsp_function_code (rsp_bus.function_code),
      .rsp_data_first    (rsp_bus.data_first),
      .rsp_data_second   (rsp_bus.data_second),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .reports_pending   (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [dfr_pkg::BYTE_W-1:0] random_byte();
      logic [31:0] r;
      r = $urandom;
      return r[dfr_pkg::BYTE_W-1:0];
   endfunction

   function automatic logic [dfr_pkg::BYTE_W-1:0] random_nonzero_byte();
      logic [31:0] r;
      r = $urandom_range(1, 255);
      return r[dfr_pkg::BYTE_W-1:0];
   endfunction

   task automatic send_byte(input logic [dfr_pkg::BYTE_W-1:0] rx);
      int  gap;
      bit  taken;
      gap = (!gap_free && $urandom_range(0, 2) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= rx;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      words_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (reports_pending != 0) @(posedge clock);
      repeat (dfr_pkg::FRAME_LENGTH + 4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [dfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dfr_pkg::BYTE_W-1:0]    value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic [dfr_pkg::BYTE_W-1:0] first_byte,
                             input logic [dfr_pkg::BYTE_W-1:0] last_byte);
      logic [dfr_pkg::BYTE_W-1:0] frame [dfr_pkg::FRAME_LENGTH];
      logic [dfr_pkg::BYTE_W-1:0] check;
      frame_kind_type             kind;
      int                         pick;
      pick = $urandom_range(0, 99);
      kind = pick < 65 ? FRAME_GOOD : pick < 78 ? FRAME_BAD_SUM :
             pick < 90 ? FRAME_BAD_END : FRAME_NOISE;
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 3);
            send_byte(pick == 0 ? first_byte : pick == 1 ? last_byte : random_byte());
         end
         return;
      end
      frame[0] = first_byte;
      pick     = $urandom_range(0, 9);
      frame[1] = pick < 4 ? dfr_pkg::CODE_PAGE_ONE :
                 pick < 7 ? dfr_pkg::CODE_PAGE_TWO : random_byte();
      check    = frame[0] ^ frame[1];
      for (int i = 2; i < CHECK_POS; i++) begin
         frame[i] = ($urandom_range(0, 9) == 0) ? first_byte : random_byte();
         check ^= frame[i];
      end
      frame[CHECK_POS] = check ^
                         (kind == FRAME_BAD_SUM ? random_nonzero_byte() : '0);
      frame[dfr_pkg::FRAME_LENGTH-1] = last_byte ^
                         (kind == FRAME_BAD_END ? random_nonzero_byte() : '0);
      for (int i = 0; i < dfr_pkg::FRAME_LENGTH; i++) send_byte(frame[i]);
   endtask

   task automatic run_phase(input logic [dfr_pkg::BYTE_W-1:0] first_byte,
                            input logic [dfr_pkg::BYTE_W-1:0] last_byte,
                            input bit pressure, input bit mid_pause);
      int unsigned origin;
      drain();
      csr_write(dfr_pkg::CSR_START_BYTE, first_byte);
      csr_write(dfr_pkg::CSR_END_BYTE, last_byte);
      csr_write($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, random_byte());
      gap_free = pressure || ($urandom_range(0, 3) == 0);
      if (pressure) hold_off_requests++;
      origin = words_sent;
      while (words_sent - origin < PHASE_WORDS) begin
         send_frame(first_byte, last_byte);
         if (mid_pause && words_sent - origin >= PHASE_WORDS / 2) begin
            mid_pause = 1'b0;
            drain();
         end
      end
      gap_free = 1'b0;
   endtask

   // report side: random stalls, quiet stretches, one long hold-off on request
   initial begin
      int          stall_left;
      int          mode_left;
      bit          quiet;
      int unsigned hold_off_served;
      stall_left      = 0;
      mode_left       = 0;
      quiet           = 1'b0;
      hold_off_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            quiet     = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(100, 600);
         end else begin
            mode_left--;
         end
         if (hold_off_requests != hold_off_served) begin
            hold_off_served = hold_off_requests;
            stall_left      = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left    = gap_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      words_sent        = 0;
      gap_free          = 1'b0;
      hold_off_requests = 0;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= dfr_pkg::CSR_START_BYTE;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end byte while hunting is dropped
      send_byte(dfr_pkg::END_BYTE_RESET);
      // page one, data at both extremes
      send_byte(dfr_pkg::START_BYTE_RESET);
      send_byte(dfr_pkg::CODE_PAGE_ONE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(dfr_pkg::START_BYTE_RESET ^ dfr_pkg::CODE_PAGE_ONE ^ 8'hFF);
      send_byte(dfr_pkg::END_BYTE_RESET);
      // page two
      send_byte(dfr_pkg::START_BYTE_RESET);
      send_byte(dfr_pkg::CODE_PAGE_TWO);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(dfr_pkg::START_BYTE_RESET ^ dfr_pkg::CODE_PAGE_TWO ^ 8'hFF);
      send_byte(dfr_pkg::END_BYTE_RESET);
      // checksum mismatch
      send_byte(dfr_pkg::START_BYTE_RESET);
      send_byte(dfr_pkg::CODE_PAGE_TWO);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(dfr_pkg::END_BYTE_RESET);
      // wrong end byte; start byte inside the frame reopens on replay
      send_byte(dfr_pkg::START_BYTE_RESET);
      send_byte(dfr_pkg::END_BYTE_RESET);
      send_byte(dfr_pkg::START_BYTE_RESET);
      send_byte(dfr_pkg::CODE_PAGE_ONE);
      send_byte(8'h00);
      send_byte(8'h00);
      // closes the frame rebuilt from the replay
      send_byte(dfr_pkg::START_BYTE_RESET ^ dfr_pkg::CODE_PAGE_ONE);
      send_byte(dfr_pkg::END_BYTE_RESET);

      run_phase(dfr_pkg::START_BYTE_RESET, dfr_pkg::END_BYTE_RESET, 1'b0, 1'b0);
      run_phase(8'h00, 8'h00, 1'b0, 1'b0);
      run_phase(8'hFF, 8'h00, 1'b1, 1'b0);
      run_phase(8'h00, 8'hFF, 1'b0, 1'b0);
      run_phase(8'hFF, 8'hFF, 1'b0, 1'b1);
      run_phase(8'hA5, dfr_pkg::START_BYTE_RESET, 1'b0, 1'b0);
      run_phase(random_byte(), random_byte(), 1'b0, 1'b0);
      run_phase(random_byte(), random_byte(), 1'b0, 1'b0);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && reports_pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
